// ===== sv/rebf_pkg.sv =====
// ----------------------------------------------------------------------------
// rebf_pkg
// Shared types, constants and helpers of the root election node: link table
// entry, configuration bundle, sequencer states and saturating add.
// ----------------------------------------------------------------------------
`default_nettype none

package rebf_pkg;

  // number of links and derived widths
  localparam int LINKS        = 4;
  localparam int LINK_AW      = (LINKS > 1) ? $clog2(LINKS) : 1;
  localparam int NUM_COSTS    = 4;
  localparam int COST_AW      = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;

  localparam logic [31:0] MAX_U32 = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_COST_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_COST_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_COST_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_COST_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HELLO       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROOT_TMO    = 3'd6;

  // item operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADV  = 1'b1;

  // one link table entry
  typedef struct packed {
    logic [31:0] neighbor;
    logic [31:0] root;
    logic [31:0] cost;
    logic [31:0] deadline;
  } link_entry_t;

  localparam int ENTRY_W = $bits(link_entry_t);

  // configuration bundle
  typedef struct packed {
    logic [31:0]                node_id;
    logic [NUM_COSTS-1:0][15:0] link_cost;
    logic [15:0]                hello_interval;
    logic [19:0]                self_lifetime;
  } cfg_t;

  // control of the relaxation unit
  typedef struct packed {
    logic init;
    logic step;
  } relax_ctl_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV_RD,
    ST_ADV_WR,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // unsigned add that sticks at all ones
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? MAX_U32 : s[31:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/rebf_ram.sv =====
// ----------------------------------------------------------------------------
// rebf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rebf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/rebf_cfg.sv =====
// ----------------------------------------------------------------------------
// rebf_cfg
// Configuration register file: node id, per-link costs, hello period and
// root lifetime. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module rebf_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [rebf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rebf_pkg::CFG_DATA_W-1:0]    cfg_data,
  output rebf_pkg::cfg_t                          cfg
);

  import rebf_pkg::*;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_id        <= '0;
      for (int i = 0; i < NUM_COSTS; i++) begin
        cfg.link_cost[i] <= 16'd1;
      end
      cfg.hello_interval <= 16'd2000;
      cfg.self_lifetime  <= 20'd10000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NODE_ID:     cfg.node_id        <= cfg_data;
        REG_LINK_COST_0: cfg.link_cost[0]   <= cfg_data[15:0];
        REG_LINK_COST_1: cfg.link_cost[1]   <= cfg_data[15:0];
        REG_LINK_COST_2: cfg.link_cost[2]   <= cfg_data[15:0];
        REG_LINK_COST_3: cfg.link_cost[3]   <= cfg_data[15:0];
        REG_HELLO:       cfg.hello_interval <= cfg_data[15:0];
        REG_ROOT_TMO:    cfg.self_lifetime  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/rebf_relax.sv =====
// ----------------------------------------------------------------------------
// rebf_relax
// Running best-view accumulator: starts from the node itself and folds in
// one link table entry per step (root, then cost, then neighbor id).
// ----------------------------------------------------------------------------
`default_nettype none

module rebf_relax (
  input  wire logic                   clk,
  input  wire rebf_pkg::relax_ctl_t   ctl,
  input  wire logic [31:0]            node_id,
  input  wire logic [31:0]            time_now,
  input  wire logic                   heard,
  input  wire logic [15:0]            link_cost,
  input  wire rebf_pkg::link_entry_t  entry,
  output logic [31:0]                 best_root,
  output logic [31:0]                 best_cost,
  output logic [31:0]                 best_neighbor,
  output logic [31:0]                 best_deadline,
  output logic                        best_self
);

  import rebf_pkg::*;

  logic [31:0] path_cost;
  logic        live;
  logic        better;

  // candidate path cost and ordering test
  always_comb begin
    path_cost = sat_add(entry.cost, {16'd0, link_cost});
    live      = heard && (time_now < entry.deadline);
    better    = (entry.root < best_root) ||
                ((entry.root == best_root) && (path_cost < best_cost)) ||
                ((entry.root == best_root) && (path_cost == best_cost) &&
                 !best_self && (entry.neighbor < best_neighbor));
  end

  // accumulator registers
  always_ff @(posedge clk) begin
    if (ctl.init) begin
      best_root     <= node_id;
      best_cost     <= '0;
      best_neighbor <= '0;
      best_deadline <= '0;
      best_self     <= 1'b1;
    end else if (ctl.step && live && better) begin
      best_root     <= entry.root;
      best_cost     <= path_cost;
      best_neighbor <= entry.neighbor;
      best_deadline <= entry.deadline;
      best_self     <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/root_election_bellman_ford_node.sv =====
// ----------------------------------------------------------------------------
// root_election_bellman_ford_node
// One node of a distance-vector root election. Stores advertisements per link
// in a small table RAM, rescans the table after every beat and reports a
// changed view or a keepalive.
// ----------------------------------------------------------------------------
// Sequence: a tick or an ignored advertisement goes straight to the table scan,
//   a stored advertisement first reads then writes its entry (ADV_RD, ADV_WR);
//   the scan (SCAN, DRAIN) ends in FINISH, which registers done. A new item is
//   taken only when idle; the scan uses the single RAM read port, one link a cycle.
// Reset: synchronous; clears time, view, hello deadline and heard bits.
// The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none

module root_election_bellman_ford_node (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [rebf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rebf_pkg::CFG_DATA_W-1:0] cfg_data,
  // command
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            operation,
  input  wire logic [7:0]                      link_index,
  input  wire logic [31:0]                     neighbor_id,
  input  wire logic [31:0]                     neighbor_root,
  input  wire logic [31:0]                     neighbor_cost,
  input  wire logic [31:0]                     neighbor_life,
  // result
  output logic                                 done,
  output logic                                 view_changed,
  output logic [31:0]                          current_root,
  output logic [31:0]                          current_cost,
  output logic                                 is_self_root,
  output logic [31:0]                          parent_id,
  output logic [31:0]                          advertised_lifetime
);

  import rebf_pkg::*;

  state_t state, state_next;

  cfg_t cfg;

  // captured item
  logic               item_op;
  logic [7:0]         item_link;
  logic [31:0]        item_nid;
  logic [31:0]        item_root;
  logic [31:0]        item_cost;
  logic [31:0]        item_life;

  // node state
  logic [31:0]        time_now;
  logic [31:0]        best_root;
  logic [31:0]        best_cost;
  logic [31:0]        hello_due;
  logic [LINKS-1:0]   heard;

  // scan control
  logic [LINK_AW-1:0] scan_idx;
  logic               cmp_v;
  logic [LINK_AW-1:0] cmp_idx;
  logic               scan_last;

  // table RAM
  logic               ram_we;
  logic [LINK_AW-1:0] ram_raddr;
  link_entry_t        ram_wdata;
  link_entry_t        ram_rdata;
  logic [LINK_AW-1:0] adv_idx;
  logic               adv_store;
  logic [31:0]        adv_cand;

  // relaxation unit
  relax_ctl_t         relax_ctl;
  logic [31:0]        rx_root;
  logic [31:0]        rx_cost;
  logic [31:0]        rx_neighbor;
  logic [31:0]        rx_deadline;
  logic               rx_self;

  // finish decision
  logic               changed;
  logic               send;
  logic [31:0]        life;

  logic               accept;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign adv_idx   = item_link[LINK_AW-1:0];
  assign adv_store = (item_op == OP_ADV) && (item_link < 8'(LINKS));
  assign scan_last = (scan_idx == LINK_AW'(LINKS - 1));

  rebf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rebf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LINKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (adv_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rebf_relax u_relax (
    .clk           (clk),
    .ctl           (relax_ctl),
    .node_id       (cfg.node_id),
    .time_now      (time_now),
    .heard         (heard[cmp_idx]),
    .link_cost     (cfg.link_cost[COST_AW'(cmp_idx)]),
    .entry         (ram_rdata),
    .best_root     (rx_root),
    .best_cost     (rx_cost),
    .best_neighbor (rx_neighbor),
    .best_deadline (rx_deadline),
    .best_self     (rx_self)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((operation == OP_ADV) && (link_index < 8'(LINKS))) begin
            state_next = ST_ADV_RD;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_ADV_RD: state_next = ST_ADV_WR;
      ST_ADV_WR: state_next = ST_SCAN;
      ST_SCAN:   state_next = scan_last ? ST_DRAIN : ST_SCAN;
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ram_raddr      = scan_idx;
    ram_we         = 1'b0;
    relax_ctl.init = 1'b0;
    relax_ctl.step = cmp_v;
    case (state)
      ST_ADV_RD: ram_raddr = adv_idx;
      ST_ADV_WR: ram_we = adv_store;
      ST_SCAN:   relax_ctl.init = (scan_idx == '0);
      default: ;
    endcase
  end

  // merged advertisement entry, deadline only moves later on same root
  always_comb begin
    adv_cand            = sat_add(time_now, item_life);
    ram_wdata.neighbor  = item_nid;
    ram_wdata.root      = item_root;
    ram_wdata.cost      = item_cost;
    ram_wdata.deadline  = adv_cand;
    if (heard[adv_idx] && (ram_rdata.root == item_root) &&
        (ram_rdata.deadline > adv_cand)) begin
      ram_wdata.deadline = ram_rdata.deadline;
    end
  end

  // report decision
  always_comb begin
    changed = (rx_root != best_root) || (rx_cost != best_cost);
    send    = changed || (time_now >= hello_due);
    if (rx_self) begin
      life = {12'd0, cfg.self_lifetime};
    end else if (rx_deadline > time_now) begin
      life = rx_deadline - time_now;
    end else begin
      life = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      time_now  <= '0;
      best_root <= '0;
      best_cost <= '0;
      hello_due <= '0;
      heard     <= '0;
      scan_idx  <= '0;
      cmp_v     <= 1'b0;
      done      <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_FINISH) && send;
      cmp_v <= (state == ST_SCAN);
      // millisecond tick advances time, sticking at all ones
      if (accept && (operation == OP_TICK) && (time_now != MAX_U32)) begin
        time_now <= time_now + 32'd1;
      end
      if (ram_we) begin
        heard[adv_idx] <= 1'b1;
      end
      // table scan index
      if (state == ST_SCAN) begin
        scan_idx <= scan_last ? '0 : scan_idx + LINK_AW'(1);
      end
      // commit view and restart the hello timer on a send
      if (state == ST_FINISH) begin
        best_root <= rx_root;
        best_cost <= rx_cost;
        if (send) begin
          hello_due <= sat_add(time_now, {16'd0, cfg.hello_interval});
        end
      end
    end
  end

  // item capture and compare index
  always_ff @(posedge clk) begin
    if (accept) begin
      item_op   <= operation;
      item_link <= link_index;
      item_nid  <= neighbor_id;
      item_root <= neighbor_root;
      item_cost <= neighbor_cost;
      item_life <= neighbor_life;
    end
    cmp_idx <= scan_idx;
  end

  // result beat
  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && send) begin
      view_changed        <= changed;
      current_root        <= rx_root;
      current_cost        <= rx_cost;
      is_self_root        <= rx_self;
      parent_id           <= rx_self ? 32'd0 : rx_neighbor;
      advertised_lifetime <= life;
    end
  end

  // checks
  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("result strobe without a finished scan");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start the sequencer");

  a_self_no_parent: assert property (@(posedge clk) disable iff (rst)
    (done && is_self_root) |-> (parent_id == 32'd0))
    else $error("self root reported with a parent id");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> $past(state == ST_ADV_RD))
    else $error("table write without a preceding entry read");

endmodule

`default_nettype wire
